// ===== sv/tstw_pkg.sv =====
`default_nettype none

package tstw_pkg;

    // Port widths fixed by the field list
    localparam int CHAR_W     = 8;
    localparam int ROW_PORT_W = 5;
    localparam int COL_PORT_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int CELL_W     = 16;

    // Byte codes
    localparam logic [7:0] CODE_BELL     = 8'd7;
    localparam logic [7:0] CODE_BS       = 8'd8;
    localparam logic [7:0] CODE_TAB      = 8'd9;
    localparam logic [7:0] CODE_LF       = 8'd10;
    localparam logic [7:0] CODE_CR       = 8'd13;
    localparam logic [7:0] CODE_ESC      = 8'd27;
    localparam logic [7:0] CODE_LBRACKET = 8'h5B;
    localparam logic [7:0] CODE_TWO      = 8'h32;
    localparam logic [7:0] CODE_J        = 8'h4A;
    localparam logic [7:0] BLANK_CHAR    = 8'h20;
    localparam logic [7:0] RESET_ATTR    = 8'h07;

    // Commands
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ_REQ,
        ST_READ_WAIT,
        ST_BYTE,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_SCROLL_BLANK,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_SEEN,
        ESC_BRACKET,
        ESC_DIGIT
    } esc_stage_t;

endpackage

`default_nettype wire

// ===== sv/tstw_ram.sv =====
`default_nettype none

module tstw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/tstw_addr.sv =====
`default_nettype none

// Shared cell address unit: row * COLUMNS + col
module tstw_addr #(
    parameter int COLUMNS = 80,
    parameter int ROW_W   = 5,
    parameter int COL_W   = 7,
    parameter int ADDR_W  = 11
) (
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [COL_W-1:0]  col,
    output logic      [ADDR_W-1:0] addr
);

    logic [ADDR_W-1:0] row_base;

    assign row_base = ADDR_W'(row) * ADDR_W'(COLUMNS);
    assign addr     = row_base + ADDR_W'(col);

endmodule

`default_nettype wire

// ===== sv/text_screen_terminal_writer.sv =====
// Channel   Handshake          Payload
// config    cfg_we             cfg_index, cfg_data
// request   start && !busy     cmd, char_byte, read_row, read_col
// result    done (one cycle)   cell_char, cell_attr, cursor_row_now, cursor_col_now,
//                              bell, accepted
//
// A read goes from the accept cycle through a request and a wait state to done; an
// off-screen read skips the wait. A put runs its bytes in the byte state; a disabled
// put, or one that only holds an escape byte, goes straight to done. A scroll walks the
// cell RAM through its one read and one write port, moving each cell up a row, then
// blanks the last row. Clear screen blanks every cell. The receiver cannot stall.
// After reset the RAM is blanked, one cell a cycle, with busy high; config writes are
// taken meanwhile.
`default_nettype none

module text_screen_terminal_writer
    import tstw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  cmd,
    input  wire logic [CHAR_W-1:0]     char_byte,
    input  wire logic [ROW_PORT_W-1:0] read_row,
    input  wire logic [COL_PORT_W-1:0] read_col,
    output logic                       done,
    output logic [CHAR_W-1:0]          cell_char,
    output logic [CHAR_W-1:0]          cell_attr,
    output logic [ROW_PORT_W-1:0]      cursor_row_now,
    output logic [COL_PORT_W-1:0]      cursor_col_now,
    output logic                       bell,
    output logic                       accepted
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + TAB_WIDTH);
    localparam int PH_W   = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

    localparam logic [ADDR_W-1:0] CELL_LAST   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(COLUMNS * (ROWS - 1) - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [PH_W-1:0]   PH_LAST     = PH_W'(TAB_WIDTH - 1);

    state_t     state_reg, state_next;
    esc_stage_t esc_reg, esc_next;

    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [PH_W-1:0]       phase_reg, phase_next;
    logic [ADDR_W-1:0]     lin_reg, lin_next;
    logic [1:0]            q_cnt_reg, q_cnt_next;
    logic [1:0]            q_idx_reg, q_idx_next;
    logic                  bell_reg, bell_next;
    logic                  acc_reg, acc_next;
    logic                  out_en_reg;
    logic [CHAR_W-1:0]     attr_reg;

    logic [CHAR_W-1:0]     q_reg [3];
    logic [CHAR_W-1:0]     q_next [3];
    logic [ROW_PORT_W-1:0] rrow_reg;
    logic [COL_PORT_W-1:0] rcol_reg;
    logic [CHAR_W-1:0]     cell_char_reg, cell_char_next;
    logic [CHAR_W-1:0]     cell_attr_reg, cell_attr_next;

    // Escape decode results
    logic [CHAR_W-1:0]     dq [3];
    logic [1:0]            dq_cnt;
    esc_stage_t            desc;
    logic                  dclear;

    // Byte step results
    logic [CHAR_W-1:0]     cur_byte;
    logic [COL_W-1:0]      col_inc;
    logic [COL_W-1:0]      col_tab;
    logic                  line_feed;
    logic                  scroll_go;
    logic                  more_bytes;
    logic                  read_in_range;
    logic                  accept;

    logic [ROW_W-1:0]      au_row;
    logic [COL_W-1:0]      au_col;
    logic [ADDR_W-1:0]     au_addr;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [CELL_W-1:0]     mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [CELL_W-1:0]     mem_rdata;

    tstw_addr #(
        .COLUMNS (COLUMNS),
        .ROW_W   (ROW_W),
        .COL_W   (COL_W),
        .ADDR_W  (ADDR_W)
    ) u_addr (
        .row  (au_row),
        .col  (au_col),
        .addr (au_addr)
    );

    tstw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept        = start && !busy;
    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign read_in_range = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLUMNS);

    assign cur_byte   = q_reg[q_idx_reg];
    assign col_inc    = col_reg + COL_W'(1);
    assign col_tab    = col_reg + COL_W'(TAB_WIDTH) - COL_W'(phase_reg);
    assign more_bytes = ((q_idx_reg + 2'd1) < q_cnt_reg);

    // Escape sequence decode: bytes to run as ordinary ones, in order
    always_comb
    begin
        dq[0]  = char_byte;
        dq[1]  = char_byte;
        dq[2]  = char_byte;
        dq_cnt = 2'd0;
        desc   = esc_reg;
        dclear = 1'b0;
        unique case (esc_reg)
            ESC_NONE:
            begin
                if (char_byte == CODE_ESC)
                begin
                    desc = ESC_SEEN;
                end
                else
                begin
                    dq_cnt = 2'd1;
                end
            end
            ESC_SEEN:
            begin
                if (char_byte == CODE_LBRACKET)
                begin
                    desc = ESC_BRACKET;
                end
                else if (char_byte == CODE_ESC)
                begin
                    desc = ESC_SEEN;
                end
                else
                begin
                    desc   = ESC_NONE;
                    dq_cnt = 2'd1;
                end
            end
            ESC_BRACKET:
            begin
                if (char_byte == CODE_TWO)
                begin
                    desc = ESC_DIGIT;
                end
                else
                begin
                    dq[0] = CODE_LBRACKET;
                    if (char_byte == CODE_ESC)
                    begin
                        desc   = ESC_SEEN;
                        dq_cnt = 2'd1;
                    end
                    else
                    begin
                        desc   = ESC_NONE;
                        dq_cnt = 2'd2;
                    end
                end
            end
            ESC_DIGIT:
            begin
                if (char_byte == CODE_J)
                begin
                    desc   = ESC_NONE;
                    dclear = 1'b1;
                end
                else
                begin
                    dq[0] = CODE_LBRACKET;
                    dq[1] = CODE_TWO;
                    if (char_byte == CODE_ESC)
                    begin
                        desc   = ESC_SEEN;
                        dq_cnt = 2'd2;
                    end
                    else
                    begin
                        desc   = ESC_NONE;
                        dq_cnt = 2'd3;
                    end
                end
            end
            default:
            begin
                desc = ESC_NONE;
            end
        endcase
    end

    // Line feed request of the byte now being run
    always_comb
    begin
        line_feed = 1'b0;
        case (cur_byte) inside
            CODE_BS, CODE_BELL, CODE_CR: line_feed = 1'b0;
            CODE_TAB:                    line_feed = (col_tab >= COL_W'(COLUMNS));
            CODE_LF:                     line_feed = 1'b1;
            default:                     line_feed = (col_inc >= COL_W'(COLUMNS));
        endcase
    end

    assign scroll_go = line_feed && (row_reg == LAST_ROW);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (lin_reg == CELL_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_READ)
                    begin
                        state_next = ST_READ_REQ;
                    end
                    else if (!out_en_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (dclear)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (dq_cnt != 2'd0)
                    begin
                        state_next = ST_BYTE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ_REQ:
            begin
                state_next = read_in_range ? ST_READ_WAIT : ST_DONE;
            end
            ST_READ_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_BYTE:
            begin
                if (scroll_go)
                begin
                    state_next = ST_SCROLL_RD;
                end
                else if (!more_bytes)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL_RD:
            begin
                state_next = ST_SCROLL_WR;
            end
            ST_SCROLL_WR:
            begin
                state_next = (lin_reg == SCROLL_LAST) ? ST_SCROLL_BLANK : ST_SCROLL_RD;
            end
            ST_SCROLL_BLANK:
            begin
                if (lin_reg == CELL_LAST)
                begin
                    // q_idx already points past the byte that scrolled
                    state_next = (q_idx_reg < q_cnt_reg) ? ST_BYTE : ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                if (lin_reg == CELL_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        esc_next       = esc_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        lin_next       = lin_reg;
        q_cnt_next     = q_cnt_reg;
        q_idx_next     = q_idx_reg;
        q_next         = q_reg;
        bell_next      = bell_reg;
        acc_next       = acc_reg;
        cell_char_next = cell_char_reg;
        cell_attr_next = cell_attr_reg;
        au_row         = row_reg;
        au_col         = col_reg;
        mem_we         = 1'b0;
        mem_waddr      = au_addr;
        mem_wdata      = {attr_reg, BLANK_CHAR};
        mem_raddr      = au_addr;

        unique case (state_reg) inside
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = lin_reg;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
                lin_next  = (lin_reg == CELL_LAST) ? '0 : lin_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    bell_next      = 1'b0;
                    cell_char_next = '0;
                    cell_attr_next = '0;
                    acc_next       = (cmd == CMD_PUT) && out_en_reg;
                    q_idx_next     = 2'd0;
                    q_cnt_next     = 2'd0;
                    lin_next       = '0;
                    if ((cmd == CMD_PUT) && out_en_reg)
                    begin
                        esc_next   = desc;
                        q_next     = dq;
                        q_cnt_next = dq_cnt;
                        if (dclear)
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            phase_next = '0;
                        end
                    end
                end
            end
            ST_READ_REQ:
            begin
                au_row = ROW_W'(rrow_reg);
                au_col = COL_W'(rcol_reg);
            end
            ST_READ_WAIT:
            begin
                cell_char_next = mem_rdata[7:0];
                cell_attr_next = mem_rdata[15:8];
            end
            ST_BYTE:
            begin
                q_idx_next = q_idx_reg + 2'd1;
                case (cur_byte)
                    CODE_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            au_col     = col_reg - COL_W'(1);
                            mem_we     = 1'b1;
                            col_next   = col_reg - COL_W'(1);
                            phase_next = (phase_reg == '0) ? PH_LAST : phase_reg - PH_W'(1);
                        end
                    end
                    CODE_BELL:
                    begin
                        bell_next = 1'b1;
                    end
                    CODE_TAB:
                    begin
                        col_next   = col_tab;
                        phase_next = '0;
                    end
                    CODE_CR:
                    begin
                        col_next   = '0;
                        phase_next = '0;
                    end
                    CODE_LF:
                    begin
                        col_next = col_reg;
                    end
                    default:
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = {attr_reg, cur_byte};
                        col_next   = col_inc;
                        phase_next = (phase_reg == PH_LAST) ? '0 : phase_reg + PH_W'(1);
                    end
                endcase
                if (line_feed)
                begin
                    col_next   = '0;
                    phase_next = '0;
                    if (!scroll_go)
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                    lin_next = '0;
                end
            end
            ST_SCROLL_RD:
            begin
                mem_raddr = lin_reg + ADDR_W'(COLUMNS);
            end
            ST_SCROLL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = lin_reg;
                mem_wdata = mem_rdata;
                lin_next  = lin_reg + ADDR_W'(1);
            end
            ST_SCROLL_BLANK, ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = lin_reg;
                lin_next  = (lin_reg == CELL_LAST) ? '0 : lin_reg + ADDR_W'(1);
            end
            ST_DONE:
            begin
                lin_next = '0;
            end
            default:
            begin
                lin_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            esc_reg    <= ESC_NONE;
            row_reg    <= '0;
            col_reg    <= '0;
            phase_reg  <= '0;
            lin_reg    <= '0;
            q_cnt_reg  <= '0;
            q_idx_reg  <= '0;
            bell_reg   <= 1'b0;
            acc_reg    <= 1'b0;
            out_en_reg <= 1'b0;
            attr_reg   <= RESET_ATTR;
        end
        else
        begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            lin_reg   <= lin_next;
            q_cnt_reg <= q_cnt_next;
            q_idx_reg <= q_idx_next;
            bell_reg  <= bell_next;
            acc_reg   <= acc_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_OUTPUT_ENABLE:  out_en_reg <= cfg_data[0];
                    REG_TEXT_ATTRIBUTE: attr_reg   <= cfg_data;
                    default:            out_en_reg <= out_en_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        cell_char_reg <= cell_char_next;
        cell_attr_reg <= cell_attr_next;
        if (accept)
        begin
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
    end

    assign cell_char      = cell_char_reg;
    assign cell_attr      = cell_attr_reg;
    assign cursor_row_now = ROW_PORT_W'(row_reg);
    assign cursor_col_now = COL_PORT_W'(col_reg);
    assign bell           = bell_reg;
    assign accepted       = acc_reg;

    // A result strobe is never held high back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request accepted without going busy");

    // Cursor is on the screen whenever the block is idle
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((int'(row_reg) < ROWS) && (int'(col_reg) < COLUMNS)))
        else $error("cursor off screen while idle");

    // Byte queue index never runs past its fill
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BYTE) |-> (q_idx_reg < q_cnt_reg))
        else $error("byte queue index past fill");

endmodule

`default_nettype wire
